// ===== hw/rtl/clipped_pixel_write_rgb_to_cmyk_core_assert.svh =====
// assertion macros for the clipped pixel write converter
// used by the checker module; no other dependencies
`ifndef CLIPPED_PIXEL_WRITE_RGB_TO_CMYK_CORE_ASSERT_SVH
`define CLIPPED_PIXEL_WRITE_RGB_TO_CMYK_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CPWC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cpwc assertion failed");

// next-cycle implication, disabled in reset
`define CPWC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cpwc assertion failed");

`endif

// ===== hw/rtl/cpwc_pkg.sv =====
// shared types and constants of the clipped pixel write converter
// no dependencies
package cpwc_pkg;

    localparam int CH_W      = 8;
    localparam int POS_W     = 16;
    localparam int DIM_W     = 13;
    localparam int OFF_W     = 26;
    localparam int DIVD_W    = 16;
    localparam int NUM_LANES = 3;
    localparam int QUO_W     = 8;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        CFG_CMYK_MODE    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [CH_W-1:0]         red;
        logic [CH_W-1:0]         green;
        logic [CH_W-1:0]         blue;
    } pixel_t;

    typedef struct packed {
        logic [OFF_W-1:0] byte_offset;
        logic [CH_W-1:0]  sample_zero;
        logic [CH_W-1:0]  sample_one;
        logic [CH_W-1:0]  sample_two;
        logic [CH_W-1:0]  sample_three;
    } result_t;

    typedef struct packed {
        logic [1:0]       index;
        logic [DIM_W-1:0] value;
    } cfg_write_t;

    // front stage output: clipped, product formed, dividends ready
    typedef struct packed {
        logic                                 cmyk;
        logic [OFF_W-1:0]                     prod;
        logic [DIM_W-1:0]                     x;
        logic [CH_W-1:0]                      mx;
        logic [NUM_LANES-1:0][DIVD_W-1:0]     dividend;
        logic [NUM_LANES-1:0][CH_W-1:0]       rgb;
    } front_t;

    // item travelling along the divider cells
    typedef struct packed {
        logic                                 cmyk;
        logic [OFF_W-1:0]                     offset;
        logic [CH_W-1:0]                      divisor;
        logic [NUM_LANES-1:0][DIVD_W-1:0]     rem;
        logic [NUM_LANES-1:0][QUO_W-1:0]      quo;
        logic [NUM_LANES-1:0][CH_W-1:0]       rgb;
    } cell_t;

endpackage

// ===== hw/rtl/cpwc_stream_if.sv =====
// valid/ready channel carrying one item of a chosen type
// no dependencies
interface cpwc_stream_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cpwc_front.sv =====
// front stage: clipping, row product, channel maximum and ink dividends
// depends on cpwc_pkg
module cpwc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  cpwc_pkg::pixel_t in_pixel,
    input  logic            cmyk_mode,
    input  logic [12:0]     image_width,
    input  logic [12:0]     image_height,
    output logic            out_valid,
    output cpwc_pkg::front_t out_front
);
    import cpwc_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    front_t          front_reg;
    front_t          front_next;
    logic            x_ok;
    logic            y_ok;
    logic [CH_W-1:0] mx_rg;
    logic [CH_W-1:0] mx;
    logic [NUM_LANES-1:0][CH_W-1:0] chan;
    logic [CH_W-1:0] diff;

    always_comb
    begin
        x_ok = !in_pixel.pos_x[POS_W-1]
            && (in_pixel.pos_x[POS_W-2:0] < {{(POS_W-1-DIM_W){1'b0}}, image_width});
        y_ok = !in_pixel.pos_y[POS_W-1]
            && (in_pixel.pos_y[POS_W-2:0] < {{(POS_W-1-DIM_W){1'b0}}, image_height});
        valid_next = in_valid && x_ok && y_ok;

        chan[0] = in_pixel.red;
        chan[1] = in_pixel.green;
        chan[2] = in_pixel.blue;
        mx_rg = (chan[0] > chan[1]) ? chan[0] : chan[1];
        mx    = (mx_rg > chan[2]) ? mx_rg : chan[2];

        front_next.cmyk = cmyk_mode;
        // y is below the height here, so its low bits carry the whole row
        front_next.prod = OFF_W'(in_pixel.pos_y[DIM_W-1:0]) * OFF_W'(image_width);
        front_next.x    = in_pixel.pos_x[DIM_W-1:0];
        front_next.mx   = mx;
        front_next.rgb  = chan;
        diff = '0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            diff = mx - chan[l];
            // 255 * diff as a shift and a subtract
            front_next.dividend[l] = {diff, {CH_W{1'b0}}} - {{CH_W{1'b0}}, diff};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_reg <= front_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_front = front_reg;

endmodule

// ===== hw/rtl/cpwc_div_cell.sv =====
// one restoring division cell: settles one quotient bit for all three inks
// depends on cpwc_pkg
module cpwc_div_cell #(
    parameter int BIT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  cpwc_pkg::cell_t in_cell,
    output logic           out_valid,
    output cpwc_pkg::cell_t out_cell
);
    import cpwc_pkg::*;

    logic              valid_reg;
    cell_t             cell_reg;
    cell_t             cell_next;
    logic [DIVD_W-1:0] step_sub;

    always_comb
    begin
        cell_next = in_cell;
        step_sub  = {{(DIVD_W-CH_W){1'b0}}, in_cell.divisor} << BIT;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            // zero divisor means pure black: quotient stays zero
            if ((in_cell.divisor != '0) && (in_cell.rem[l] >= step_sub))
            begin
                cell_next.rem[l]      = in_cell.rem[l] - step_sub;
                cell_next.quo[l][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

// ===== hw/rtl/clipped_pixel_write_rgb_to_cmyk_core.sv =====
// top level of the clipped pixel write converter with rgb to cmyk inks
// depends on cpwc_pkg, cpwc_stream_if, cpwc_front, cpwc_div_cell
//
//   channel  | dir | payload      | notes
//   ---------+-----+--------------+-----------------------------------------
//   pixel    | in  | pixel_t      | one pixel write per item
//   result   | out | result_t     | zero or one item per pixel write
//   cfg      | in  | cfg_write_t  | register writes, always ready
//
// one item enters per cycle while the skid is empty; from pixel accept to result
// valid an item passes the front stage, eight divider cells and the output register
// the divider chain settles one quotient bit per cell, msb first
// reset clears all valid flags and sets rgb mode with 4096 x 4096
// a stalled result fills the skid register, which freezes the whole pipe and
// drops pixel ready on the next cycle; ready returns once the skid drains
module clipped_pixel_write_rgb_to_cmyk_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    cpwc_stream_if.sink   pixel,
    cpwc_stream_if.source result,
    cpwc_stream_if.sink   cfg
);
    import cpwc_pkg::*;

    localparam int NUM_CELLS = QUO_W;
    // the 13-bit registers cannot exceed this anyway
    localparam int DIM_CAP = (MAX_DIM < (2 ** DIM_W - 1)) ? MAX_DIM : (2 ** DIM_W - 1);
    localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_W'(DIM_CAP);
    localparam logic [DIM_W-1:0] DIM_RESET = (4096 > DIM_CAP) ? DIM_CAP_V : DIM_W'(4096);

    // configuration registers, dimensions stored already clamped
    logic             cmyk_mode_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] dim_next;

    // pipeline
    logic             adv;
    logic             front_valid;
    front_t           front_q;
    logic [OFF_W-1:0] offset_sum;
    logic             chain_valid [0:NUM_CELLS];
    cell_t            chain_cell [0:NUM_CELLS];
    result_t          pipe_item;

    // output register and skid
    logic             out_valid_reg;
    result_t          out_item_reg;
    logic             skid_valid_reg;
    result_t          skid_item_reg;

    // ---------------- configuration port ----------------
    assign cfg.ready = 1'b1;
    assign dim_next  = (cfg.data.value > DIM_CAP_V) ? DIM_CAP_V : cfg.data.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmyk_mode_reg <= 1'b0;
            width_reg     <= DIM_RESET;
            height_reg    <= DIM_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                CFG_CMYK_MODE:    cmyk_mode_reg <= cfg.data.value[0];
                CFG_IMAGE_WIDTH:  width_reg     <= dim_next;
                CFG_IMAGE_HEIGHT: height_reg    <= dim_next;
                default:          ;   // unknown index: write ignored
            endcase
        end
    end

    // ---------------- front stage ----------------
    // whole pipe moves together unless the skid holds an item
    assign adv         = !skid_valid_reg;
    assign pixel.ready = adv;

    cpwc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (pixel.valid),
        .in_pixel     (pixel.data),
        .cmyk_mode    (cmyk_mode_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .out_valid    (front_valid),
        .out_front    (front_q)
    );

    // offset = (y*w + x) * samples, wrapped to 26 bits; feeds the first cell
    always_comb
    begin
        offset_sum = front_q.prod + {{(OFF_W-DIM_W){1'b0}}, front_q.x};

        chain_valid[0]        = front_valid;
        chain_cell[0].cmyk    = front_q.cmyk;
        chain_cell[0].offset  = front_q.cmyk ? {offset_sum[OFF_W-3:0], 2'b00}
                                             : offset_sum + {offset_sum[OFF_W-2:0], 1'b0};
        chain_cell[0].divisor = front_q.mx;
        chain_cell[0].rem     = front_q.dividend;
        chain_cell[0].quo     = '0;
        chain_cell[0].rgb     = front_q.rgb;
    end

    // ---------------- divider chain, msb first ----------------
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        cpwc_div_cell #(
            .BIT (NUM_CELLS - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[k]),
            .in_cell   (chain_cell[k]),
            .out_valid (chain_valid[k+1]),
            .out_cell  (chain_cell[k+1])
        );
    end

    // ---------------- sample selection ----------------
    always_comb
    begin
        pipe_item.byte_offset = chain_cell[NUM_CELLS].offset;
        if (chain_cell[NUM_CELLS].cmyk)
        begin
            pipe_item.sample_zero  = chain_cell[NUM_CELLS].quo[0];
            pipe_item.sample_one   = chain_cell[NUM_CELLS].quo[1];
            pipe_item.sample_two   = chain_cell[NUM_CELLS].quo[2];
            // black is 255 - max
            pipe_item.sample_three = ~chain_cell[NUM_CELLS].divisor;
        end
        else
        begin
            pipe_item.sample_zero  = chain_cell[NUM_CELLS].rgb[0];
            pipe_item.sample_one   = chain_cell[NUM_CELLS].rgb[1];
            pipe_item.sample_two   = chain_cell[NUM_CELLS].rgb[2];
            pipe_item.sample_three = '0;
        end
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            if (chain_valid[NUM_CELLS])
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    // result stalled: park the arriving item
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (result.ready)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            if (chain_valid[NUM_CELLS])
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_item_reg <= pipe_item;
                end
                else
                begin
                    skid_item_reg <= pipe_item;
                end
            end
        end
        else if (result.ready)
        begin
            out_item_reg <= skid_item_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_item_reg;

endmodule

// ===== hw/rtl/cpwc_checker.sv =====
// port-level checks on the converter's result channel, bound to the top level
// depends on cpwc_pkg and clipped_pixel_write_rgb_to_cmyk_core_assert.svh
`include "clipped_pixel_write_rgb_to_cmyk_core_assert.svh"

module cpwc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input cpwc_pkg::result_t res_data
);
    import cpwc_pkg::*;

    logic nonzero_black;
    logic offset_aligned;
    logic full_black;
    logic no_color_ink;

    assign nonzero_black  = res_valid && (res_data.sample_three != '0);
    assign offset_aligned = (res_data.byte_offset[1:0] == 2'b00);
    assign full_black     = res_valid && (res_data.sample_three == {CH_W{1'b1}});
    assign no_color_ink   = (res_data.sample_zero == '0) && (res_data.sample_one == '0)
        && (res_data.sample_two == '0);

    // a stalled result keeps its valid
    `CPWC_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)

    // a stalled result keeps its payload
    `CPWC_ASSERT_NXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(res_data))

    // a nonzero black sample only comes with four samples per pixel
    `CPWC_ASSERT_IMP(a_black_aligned, clk, rst_n, nonzero_black, offset_aligned)

    // full black carries no cyan, magenta or yellow
    `CPWC_ASSERT_IMP(a_pure_black, clk, rst_n, full_black, no_color_ink)

endmodule

bind clipped_pixel_write_rgb_to_cmyk_core cpwc_checker u_cpwc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);

// ===== tb/sv/cpwc_pixel_checker.sv =====
// watches the pixel, result and register channels of the pixel write converter
// and checks every result; depends on cpwc_pkg
module cpwc_pixel_checker #(
    parameter int MAX_DIM = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    input  logic                 pixel_ready,
    input  cpwc_pkg::pixel_t     pixel_data,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  cpwc_pkg::result_t    result_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  cpwc_pkg::cfg_write_t cfg_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   checked
);
    import cpwc_pkg::*;

    logic             cmyk_sel;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    result_t pending_writes[$];
    result_t pred_item;
    result_t due_item;

    int mismatch_count = 0;
    int pending_count  = 0;
    int checked_count  = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = pending_count;
    assign checked     = checked_count;

    function automatic logic [CH_W-1:0] ink_level(input int unsigned peak,
                                                  input int unsigned level);
        int unsigned q;
        q = (255 * (peak - level)) / peak;
        return q[CH_W-1:0];
    endfunction

    // returns 1 when the write lands inside the image
    function automatic bit predict_pixel_write(input pixel_t p, output result_t r);
        int                px;
        int                py;
        int                weff;
        int                heff;
        int unsigned       peak;
        longint unsigned   lin;
        px   = $signed(p.pos_x);
        py   = $signed(p.pos_y);
        weff = (int'(width_reg) > MAX_DIM) ? MAX_DIM : int'(width_reg);
        heff = (int'(height_reg) > MAX_DIM) ? MAX_DIM : int'(height_reg);
        r    = '0;
        if (px < 0 || py < 0 || px >= weff || py >= heff)
            return 1'b0;
        lin = (longint'(py) * weff + px) * (cmyk_sel ? 4 : 3);
        r.byte_offset = lin[OFF_W-1:0];
        if (!cmyk_sel)
        begin
            r.sample_zero = p.red;
            r.sample_one  = p.green;
            r.sample_two  = p.blue;
        end
        else
        begin
            peak = p.red;
            if (p.green > peak)
                peak = p.green;
            if (p.blue > peak)
                peak = p.blue;
            // pure black: no ink on the colour planes
            if (peak != 0)
            begin
                r.sample_zero = ink_level(peak, p.red);
                r.sample_one  = ink_level(peak, p.green);
                r.sample_two  = ink_level(peak, p.blue);
            end
            r.sample_three = 8'(255 - peak);
        end
        return 1'b1;
    endfunction

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmyk_sel   <= 1'b0;
            width_reg  <= DIM_W'(4096);
            height_reg <= DIM_W'(4096);
        end
        else
        begin
            // results first, so a write accepted at this edge never matches one
            if (result_valid && result_ready)
            begin
                if (pending_writes.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual offset %0d",
                             $time, result_data.byte_offset);
                end
                else
                begin
                    due_item = pending_writes.pop_front();
                    compare_field("byte_offset", due_item.byte_offset, result_data.byte_offset);
                    compare_field("sample_zero", due_item.sample_zero, result_data.sample_zero);
                    compare_field("sample_one", due_item.sample_one, result_data.sample_one);
                    compare_field("sample_two", due_item.sample_two, result_data.sample_two);
                    compare_field("sample_three", due_item.sample_three,
                                  result_data.sample_three);
                    checked_count++;
                end
            end
            if (pixel_valid && pixel_ready)
            begin
                if (predict_pixel_write(pixel_data, pred_item))
                    pending_writes.push_back(pred_item);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_data.index)
                    CFG_CMYK_MODE:    cmyk_sel   <= cfg_data.value[0];
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data.value;
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data.value;
                    default:          ;
                endcase
            end
            pending_count <= pending_writes.size();
        end
    end

endmodule

// ===== tb/sv/clipped_pixel_write_rgb_to_cmyk_core_tb.sv =====
// testbench top of the clipped pixel write converter: stimulus and verdict
// depends on cpwc_pkg, cpwc_stream_if, cpwc_pixel_checker and the core
module clipped_pixel_write_rgb_to_cmyk_core_tb;
    import cpwc_pkg::*;

    localparam int MAX_DIM      = 4096;
    // front stage, eight divider cells, output register, plus margin
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_OFF     = 150;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int IDLE_PCT     = 13;

    // register index that decodes to nothing
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    // shared knobs between the stimulus and the sink side
    bit quiet_stretch = 1'b0;
    bit hold_off_req  = 1'b0;

    int writes_sent      = 0;
    int settings_applied = 0;
    int cycle_count      = 0;

    int mismatches;
    int outstanding;
    int checked;

    cpwc_stream_if #(.item_t(pixel_t))     pixel_if ();
    cpwc_stream_if #(.item_t(result_t))    result_if ();
    cpwc_stream_if #(.item_t(cfg_write_t)) cfg_if ();

    clipped_pixel_write_rgb_to_cmyk_core #(
        .MAX_DIM(MAX_DIM)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_if),
        .result(result_if),
        .cfg   (cfg_if)
    );

    cpwc_pixel_checker #(
        .MAX_DIM(MAX_DIM)
    ) pixel_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_if.valid),
        .pixel_ready (pixel_if.ready),
        .pixel_data  (pixel_if.data),
        .result_valid(result_if.valid),
        .result_ready(result_if.ready),
        .result_data (result_if.data),
        .cfg_valid   (cfg_if.valid),
        .cfg_ready   (cfg_if.ready),
        .cfg_data    (cfg_if.data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always #5 clk = ~clk;

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("[clipped_pixel_write_rgb_to_cmyk_core] ERROR");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request, none when quiet
    initial
    begin : sink_side
        int unsigned hold_left;
        hold_left = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                result_if.ready <= 1'b0;
            else if (hold_left != 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_off_req)
            begin
                // one long stall so the pipe and skid fill and pixel ready drops
                result_if.ready <= 1'b0;
                hold_left = HOLD_OFF - 1;
                hold_off_req = 1'b0;
            end
            else
                result_if.ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // offer one pixel write, with random idle cycles ahead of it
    // valid stays high afterwards so back-to-back items need no toggle
    task automatic send_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        pixel_t p;
        p.pos_x = x;
        p.pos_y = y;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PCT)
        begin
            pixel_if.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_if.valid <= 1'b1;
        pixel_if.data  <= p;
        @(posedge clk);
        while (!pixel_if.ready)
            @(posedge clk);
        writes_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] value);
        cfg_write_t w;
        w.index = idx;
        w.value = value;
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= w;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    // all three registers, and optionally a write to the undecoded index
    task automatic apply_settings(input logic cmyk, input int unsigned w,
                                  input int unsigned h, input bit stray_write);
        write_reg(CFG_CMYK_MODE, DIM_W'(cmyk));
        write_reg(CFG_IMAGE_WIDTH, DIM_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, DIM_W'(h));
        // zero would clip everything if it were taken as a dimension
        if (stray_write)
            write_reg(CFG_UNUSED_INDEX, '0);
        cfg_if.valid <= 1'b0;
        settings_applied++;
    endtask

    // stop offering, wait for every expected result, then let clipped items leave
    task automatic drain_pipe();
        pixel_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly inside the image, some just outside, some anywhere in 16 bits
    function automatic logic [POS_W-1:0] pick_coord(input int unsigned span);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (span == 0)
            return (roll < 80) ? POS_W'($urandom_range(0, 15)) : POS_W'($urandom);
        if (roll < 8)
            return (roll < 4) ? '0 : POS_W'(span - 1);
        if (roll < 80)
            return POS_W'($urandom_range(0, span - 1));
        if (roll < 90)
            return (roll < 85) ? '1 : POS_W'(span);
        return POS_W'($urandom);
    endfunction

    // one register setting, then random writes until enough land on the image
    // a goal of zero means the phase runs on the item cap alone
    task automatic run_phase(input logic cmyk, input int unsigned w, input int unsigned h,
                             input int unsigned goal, input int unsigned cap,
                             input bit stray_write);
        int unsigned      weff;
        int unsigned      heff;
        int unsigned      hits;
        int unsigned      sent;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [CH_W-1:0]  cr;
        logic [CH_W-1:0]  cg;
        logic [CH_W-1:0]  cb;
        apply_settings(cmyk, w, h, stray_write);
        weff = (w > MAX_DIM) ? MAX_DIM : w;
        heff = (h > MAX_DIM) ? MAX_DIM : h;
        hits = 0;
        sent = 0;
        while ((goal == 0 || hits < goal) && sent < cap)
        begin
            x = pick_coord(weff);
            y = pick_coord(heff);
            case ($urandom_range(0, 9))
                0:
                begin
                    // pure black
                    cr = '0;
                    cg = '0;
                    cb = '0;
                end
                1:
                begin
                    // channels at their extremes
                    cr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    cg = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    cb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                default:
                begin
                    cr = CH_W'($urandom);
                    cg = CH_W'($urandom);
                    cb = CH_W'($urandom);
                end
            endcase
            send_pixel(x, y, cr, cg, cb);
            sent++;
            if ($signed(x) >= 0 && $signed(x) < int'(weff) &&
                $signed(y) >= 0 && $signed(y) < int'(heff))
                hits++;
        end
        drain_pipe();
    endtask

    initial
    begin : stimulus
        // every input known from time zero
        rst_n          = 1'b0;
        pixel_if.valid = 1'b0;
        pixel_if.data  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rgb at the reset size: corners, every clip edge, extreme coordinates
        send_pixel(16'd0, 16'd0, 8'h00, 8'h00, 8'h00);
        send_pixel(16'd4095, 16'd4095, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(16'hFFFF, 16'd0, 8'h12, 8'h34, 8'h56);
        send_pixel(16'd0, 16'hFFFF, 8'h12, 8'h34, 8'h56);
        send_pixel(16'd4096, 16'd5, 8'h01, 8'h02, 8'h03);
        send_pixel(16'd5, 16'd4096, 8'h01, 8'h02, 8'h03);
        send_pixel(16'h7FFF, 16'h8000, 8'hFF, 8'h00, 8'hFF);
        send_pixel(16'h8000, 16'h7FFF, 8'h00, 8'hFF, 8'h00);
        send_pixel(16'd1234, 16'd2345, 8'hAA, 8'h55, 8'h0F);
        drain_pipe();

        // cmyk at full size: pure black, white, primaries, tiny and uneven peaks
        apply_settings(1'b1, 4096, 4096, 1'b0);
        send_pixel(16'd0, 16'd0, 8'h00, 8'h00, 8'h00);
        send_pixel(16'd4095, 16'd4095, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(16'd1, 16'd0, 8'hFF, 8'h00, 8'h00);
        send_pixel(16'd0, 16'd1, 8'h00, 8'hFF, 8'h00);
        send_pixel(16'd2, 16'd2, 8'h00, 8'h00, 8'hFF);
        send_pixel(16'd3, 16'd3, 8'h01, 8'h00, 8'h00);
        send_pixel(16'd4, 16'd4, 8'h01, 8'h02, 8'h03);
        send_pixel(16'd100, 16'd200, 8'hFE, 8'h7F, 8'h01);
        send_pixel(16'hFFFB, 16'd7, 8'h40, 8'h80, 8'hC0);
        send_pixel(16'd4096, 16'd4095, 8'h40, 8'h80, 8'hC0);
        drain_pipe();

        // dimensions above the limit act as the limit
        run_phase(1'b1, 8191, 8191, 35, 140, 1'b0);
        // single-pixel image
        run_phase(1'b0, 1, 1, 15, 240, 1'b0);
        // zero width and zero height clip every write
        run_phase(1'b1, 0, 7, 0, 20, 1'b0);
        run_phase(1'b0, 7, 0, 0, 15, 1'b0);

        // long result stall while writes keep coming
        hold_off_req = 1'b1;
        run_phase(1'b1, 640, 480, 60, 240, 1'b0);

        // no idling on either side
        quiet_stretch = 1'b1;
        run_phase(1'b0, $urandom_range(1, MAX_DIM), $urandom_range(1, MAX_DIM), 35, 140, 1'b0);
        quiet_stretch = 1'b0;

        // undecoded register index must leave the setting alone
        run_phase(1'b1, 4096, 4096, 45, 180, 1'b1);
        run_phase(1'b0, 4097, 1, 35, 140, 1'b0);
        run_phase(1'b1, $urandom_range(0, 8191), $urandom_range(0, 8191), 35, 140, 1'b0);

        $display("covered %0d pixel writes under %0d register settings, %0d results checked",
                 writes_sent, settings_applied, checked);
        $display("rgb and cmyk, dimensions 0 to 8191, clipped and pure black pixels, long stall");
        if (mismatches == 0 && outstanding == 0)
            $display("[clipped_pixel_write_rgb_to_cmyk_core] OK");
        else
            $display("[clipped_pixel_write_rgb_to_cmyk_core] ERROR");
        $finish;
    end

endmodule
